// ----- sv/dsdc_pkg.sv -----
// Package for the dual sliding door controller.
// Widths, motion and flag codes, and lamp encoders. No dependencies.
package dsdc_pkg;

  localparam int unsigned DOOR_STEPS  = 4;
  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned PER_W       = COUNT_WIDTH + 1;
  localparam int unsigned POS_W       = 3;
  localparam int unsigned CFG_W       = 17;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [POS_W-1:0] POS_OPEN   = POS_W'(DOOR_STEPS);
  localparam logic [POS_W-1:0] POS_LAST   = POS_W'(DOOR_STEPS - 1);
  localparam logic [PER_W-1:0] PER_MAX    = PER_W'(64'd1 << COUNT_WIDTH);
  localparam logic [PER_W-1:0] PER_MIN    = PER_W'(1);

  localparam logic [1:0] MOT_IDLE  = 2'd0;
  localparam logic [1:0] MOT_OPEN  = 2'd1;
  localparam logic [1:0] MOT_CLOSE = 2'd2;

  localparam int unsigned EF_LOPEN   = 0;
  localparam int unsigned EF_ROPEN   = 1;
  localparam int unsigned EF_HELD    = 2;
  localparam int unsigned EF_CLOSING = 3;

  localparam logic [1:0] MODE_NORMAL  = 2'd0;
  localparam logic [1:0] MODE_OPENING = 2'd1;
  localparam logic [1:0] MODE_HELD    = 2'd2;
  localparam logic [1:0] MODE_CLOSING = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_OPEN_STEP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD       = 2'd2;

  typedef struct packed {
    logic [POS_W-1:0]       pos;
    logic [1:0]             mot;
    logic [COUNT_WIDTH-1:0] step_cnt;
    logic [COUNT_WIDTH-1:0] hold_cnt;
    logic                   hold_run;
  } door_t;

  typedef struct packed {
    logic held;    // emergency opening finished
    logic closed;  // closing reached zero
  } door_evt_t;

  // lamps lit from bit3 down
  function automatic logic [3:0] lamps_down(input logic [POS_W-1:0] pos);
    logic [3:0] l;
    unique case (pos)
      3'd0:    l = 4'b0000;
      3'd1:    l = 4'b1000;
      3'd2:    l = 4'b1100;
      3'd3:    l = 4'b1110;
      default: l = 4'b1111;
    endcase
    return l;
  endfunction

  // lamps lit from bit0 up
  function automatic logic [3:0] lamps_up(input logic [POS_W-1:0] pos);
    logic [3:0] l;
    unique case (pos)
      3'd0:    l = 4'b0000;
      3'd1:    l = 4'b0001;
      3'd2:    l = 4'b0011;
      3'd3:    l = 4'b0111;
      default: l = 4'b1111;
    endcase
    return l;
  endfunction

endpackage

// ----- sv/dsdc_door.sv -----
// One door: step counter, position and hold counter for one tick.
// Depends on dsdc_pkg.
module dsdc_door (
  input  dsdc_pkg::door_t                  cur_i,
  input  logic                             own_flag_i,
  input  logic [dsdc_pkg::PER_W-1:0]       open_per_i,
  input  logic [dsdc_pkg::PER_W-1:0]       close_per_i,
  input  logic [dsdc_pkg::PER_W-1:0]       hold_per_i,
  output dsdc_pkg::door_t                  nxt_o,
  output dsdc_pkg::door_evt_t              evt_o
);

  logic [dsdc_pkg::PER_W-1:0] per;
  logic [dsdc_pkg::PER_W-1:0] step_inc;
  logic [dsdc_pkg::PER_W-1:0] hold_inc;
  logic                       start;

  assign per      = (cur_i.mot == dsdc_pkg::MOT_OPEN) ? open_per_i : close_per_i;
  assign step_inc = {1'b0, cur_i.step_cnt} + dsdc_pkg::PER_W'(1);
  assign hold_inc = {1'b0, cur_i.hold_cnt} + dsdc_pkg::PER_W'(1);

  always_comb begin
    nxt_o = cur_i;
    evt_o = '0;
    start = 1'b0;
    if (cur_i.mot != dsdc_pkg::MOT_IDLE) begin
      if (step_inc < per) begin
        nxt_o.step_cnt = step_inc[dsdc_pkg::COUNT_WIDTH-1:0];
      end else begin
        nxt_o.step_cnt = '0;
        if (cur_i.mot == dsdc_pkg::MOT_OPEN) begin
          if (cur_i.pos >= dsdc_pkg::POS_LAST) begin
            nxt_o.pos = dsdc_pkg::POS_OPEN;
            nxt_o.mot = dsdc_pkg::MOT_IDLE;
            if (own_flag_i) begin
              evt_o.held = 1'b1;
            end else begin
              start = 1'b1;
            end
          end else begin
            nxt_o.pos = cur_i.pos + dsdc_pkg::POS_W'(1);
          end
        end else begin
          if (cur_i.pos <= dsdc_pkg::POS_W'(1)) begin
            nxt_o.pos    = '0;
            nxt_o.mot    = dsdc_pkg::MOT_IDLE;
            evt_o.closed = 1'b1;
          end else begin
            nxt_o.pos = cur_i.pos - dsdc_pkg::POS_W'(1);
          end
        end
      end
    end
    if (start) begin
      nxt_o.hold_cnt = '0;
      nxt_o.hold_run = 1'b1;
    end else if (cur_i.hold_run) begin
      if (hold_inc < hold_per_i) begin
        nxt_o.hold_cnt = hold_inc[dsdc_pkg::COUNT_WIDTH-1:0];
      end else begin
        nxt_o.hold_cnt = '0;
        nxt_o.hold_run = 1'b0;
        nxt_o.mot      = dsdc_pkg::MOT_CLOSE;
        nxt_o.step_cnt = '0;
      end
    end
  end

endmodule

// ----- sv/dual_sliding_door_controller.sv -----
// Top level of the dual sliding door controller: edge detect, emergency
// flags, two door units, output register with skid. Depends on dsdc_pkg, dsdc_door.
//
// channel  dir  handshake                     payload
// s_axis   in   s_axis_tvalid/s_axis_tready   tdata: left, right, emergency
// m_axis   out  m_axis_tvalid/m_axis_tready   tdata: left lamps, right lamps, mode
// cfg      in   cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// One item per cycle while s_axis_tready is high; each tick is fully worked out in
// the accepting cycle, and its result is registered in the output register or skid.
// A two-entry output (register plus skid) lets an item be taken while a
// result is stalled; s_axis_tready drops only when both are full.
// Reset closes both doors and loads the default periods.
module dual_sliding_door_controller (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // left, right, emergency, pad
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [15:0]                       m_axis_tdata,  // left_lamps, right_lamps, mode, pad
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [dsdc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [dsdc_pkg::CFG_W-1:0]        cfg_data_i
);

  logic [dsdc_pkg::PER_W-1:0] open_per_q, close_per_q, hold_per_q, cfg_per;
  dsdc_pkg::door_t            left_q, right_q, left_e, right_e, left_n, right_n;
  dsdc_pkg::door_evt_t        left_evt, right_evt;
  logic [3:0]                 flags_q, flags_e, flags_n;
  logic [2:0]                 prev_q, lev, rise;
  logic [1:0]                 mode;
  logic [15:0]                res, out_q, skid_q;
  logic                       out_valid_q, skid_valid_q;
  logic                       s_acc, m_acc;

  assign cfg_ready_o = 1'b1;
  assign s_axis_tready = !skid_valid_q;
  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_per = dsdc_pkg::PER_MIN;
    end else if (cfg_data_i > dsdc_pkg::PER_MAX) begin
      cfg_per = dsdc_pkg::PER_MAX;
    end else begin
      cfg_per = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_per_q  <= dsdc_pkg::PER_W'(1000);
      close_per_q <= dsdc_pkg::PER_W'(2000);
      hold_per_q  <= dsdc_pkg::PER_W'(20000);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        dsdc_pkg::REG_OPEN_STEP:  open_per_q  <= cfg_per;
        dsdc_pkg::REG_CLOSE_STEP: close_per_q <= cfg_per;
        dsdc_pkg::REG_HOLD:       hold_per_q  <= cfg_per;
        default: ;
      endcase
    end
  end

  // edges, emergency action and sensor hold clear
  assign lev  = s_axis_tdata[2:0];
  assign rise = lev & ~prev_q;

  always_comb begin
    left_e  = left_q;
    right_e = right_q;
    flags_e = flags_q;
    if (rise[0] && flags_q == '0) begin
      left_e.mot      = dsdc_pkg::MOT_OPEN;
      left_e.step_cnt = '0;
    end
    if (rise[1] && flags_q == '0) begin
      right_e.mot      = dsdc_pkg::MOT_OPEN;
      right_e.step_cnt = '0;
    end
    if (rise[2]) begin
      if (flags_q[dsdc_pkg::EF_HELD]) begin
        flags_e = '0;
        flags_e[dsdc_pkg::EF_CLOSING] = 1'b1;
        left_e.mot  = dsdc_pkg::MOT_CLOSE;
        right_e.mot = dsdc_pkg::MOT_CLOSE;
      end else begin
        flags_e = '0;
        flags_e[dsdc_pkg::EF_LOPEN] = 1'b1;
        flags_e[dsdc_pkg::EF_ROPEN] = 1'b1;
        left_e.mot       = dsdc_pkg::MOT_OPEN;
        right_e.mot      = dsdc_pkg::MOT_OPEN;
        left_e.hold_run  = 1'b0;
        right_e.hold_run = 1'b0;
      end
      left_e.step_cnt  = '0;
      right_e.step_cnt = '0;
    end
    if (lev[0]) left_e.hold_cnt  = '0;
    if (lev[1]) right_e.hold_cnt = '0;
  end

  dsdc_door u_left (
    .cur_i       (left_e),
    .own_flag_i  (flags_e[dsdc_pkg::EF_LOPEN]),
    .open_per_i  (open_per_q),
    .close_per_i (close_per_q),
    .hold_per_i  (hold_per_q),
    .nxt_o       (left_n),
    .evt_o       (left_evt)
  );

  dsdc_door u_right (
    .cur_i       (right_e),
    .own_flag_i  (flags_e[dsdc_pkg::EF_ROPEN]),
    .open_per_i  (open_per_q),
    .close_per_i (close_per_q),
    .hold_per_i  (hold_per_q),
    .nxt_o       (right_n),
    .evt_o       (right_evt)
  );

  always_comb begin
    flags_n = flags_e;
    if (left_evt.held) begin
      flags_n[dsdc_pkg::EF_LOPEN] = 1'b0;
      flags_n[dsdc_pkg::EF_HELD]  = 1'b1;
    end
    if (right_evt.held) begin
      flags_n[dsdc_pkg::EF_ROPEN] = 1'b0;
      flags_n[dsdc_pkg::EF_HELD]  = 1'b1;
    end
    if (left_evt.closed || right_evt.closed) begin
      flags_n[dsdc_pkg::EF_CLOSING] = 1'b0;
    end
  end

  always_comb begin
    priority if (flags_n[dsdc_pkg::EF_HELD]) begin
      mode = dsdc_pkg::MODE_HELD;
    end else if (flags_n[dsdc_pkg::EF_CLOSING]) begin
      mode = dsdc_pkg::MODE_CLOSING;
    end else if (flags_n[dsdc_pkg::EF_LOPEN] || flags_n[dsdc_pkg::EF_ROPEN]) begin
      mode = dsdc_pkg::MODE_OPENING;
    end else begin
      mode = dsdc_pkg::MODE_NORMAL;
    end
  end

  assign res = {6'b0, mode, dsdc_pkg::lamps_up(right_n.pos),
                dsdc_pkg::lamps_down(left_n.pos)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      right_q <= '0;
      flags_q <= '0;
      prev_q  <= '0;
    end else if (s_acc) begin
      left_q  <= left_n;
      right_q <= right_n;
      flags_q <= flags_n;
      prev_q  <= lev;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_acc) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= s_acc;
      end
    end else if (s_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_acc) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (s_acc) begin
        out_q <= res;
      end
    end else if (s_acc) begin
      skid_q <= res;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry without output entry");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> out_valid_q)
    else $error("accepted item produced no result");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q.pos <= dsdc_pkg::POS_OPEN && right_q.pos <= dsdc_pkg::POS_OPEN)
    else $error("door position beyond full open");

  a_held_door_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (left_evt.held || right_evt.held) |=> flags_q[dsdc_pkg::EF_HELD])
    else $error("held flag not set after emergency opening");
`endif

endmodule

// ----- tb/tb_dual_sliding_door_controller.sv -----
// Testbench for dual_sliding_door_controller: ticks of sensor and button levels in,
// lamp bars and emergency mode out, checked item by item against a local door model.
// Depends on dsdc_pkg and the dual_sliding_door_controller RTL.
`timescale 1ns / 1ps

module tb_dual_sliding_door_controller;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_TICKS    = 220;
  localparam int DIRECTED_LEN   = 27;

  typedef struct {
    logic [3:0] left_lamps;
    logic [3:0] right_lamps;
    logic [1:0] mode;
  } lamp_frame_t;

  class door_scoreboard;
    logic [dsdc_pkg::CFG_W-1:0] period_r [3];
    logic [dsdc_pkg::POS_W-1:0] pos [2];
    logic [1:0]                 mot [2];
    int unsigned                step_cnt [2];
    int unsigned                hold_cnt [2];
    logic [1:0]                 hold_run;
    logic [3:0]                 eflags;
    logic [2:0]                 prev_lev;
    lamp_frame_t                lamp_q [$];
    int                         errors;
    int                         rx_count;

    function new();
      period_r[dsdc_pkg::REG_OPEN_STEP]  = 17'd1000;
      period_r[dsdc_pkg::REG_CLOSE_STEP] = 17'd2000;
      period_r[dsdc_pkg::REG_HOLD]       = 17'd20000;
      for (int d = 0; d < 2; d++) begin
        pos[d]      = '0;
        mot[d]      = dsdc_pkg::MOT_IDLE;
        step_cnt[d] = 0;
        hold_cnt[d] = 0;
      end
      hold_run = '0;
      eflags   = '0;
      prev_lev = '0;
      errors   = 0;
      rx_count = 0;
    endfunction

    function void set_period(logic [dsdc_pkg::CFG_IDX_W-1:0] idx,
                             logic [dsdc_pkg::CFG_W-1:0] val);
      period_r[idx] = val;
    endfunction

    // zero acts as one, anything above the counter range saturates
    function int unsigned eff_ticks(logic [dsdc_pkg::CFG_W-1:0] v);
      int unsigned p;
      p = v;
      if (p == 0) p = 1;
      if (p > (32'd1 << dsdc_pkg::COUNT_WIDTH)) p = 32'd1 << dsdc_pkg::COUNT_WIDTH;
      return p;
    endfunction

    // returns 1 when the door reached full open in normal mode
    function bit advance_door(int d);
      int unsigned per;
      int unsigned c;
      if (mot[d] == dsdc_pkg::MOT_IDLE) return 1'b0;
      per = eff_ticks(mot[d] == dsdc_pkg::MOT_OPEN ? period_r[dsdc_pkg::REG_OPEN_STEP]
                                                   : period_r[dsdc_pkg::REG_CLOSE_STEP]);
      c = step_cnt[d] + 1;
      if (c < per) begin
        step_cnt[d] = c;
        return 1'b0;
      end
      step_cnt[d] = 0;
      if (mot[d] == dsdc_pkg::MOT_OPEN) begin
        if (pos[d] < dsdc_pkg::POS_OPEN) pos[d] = pos[d] + 1'b1;
        if (pos[d] >= dsdc_pkg::POS_OPEN) begin
          pos[d] = dsdc_pkg::POS_OPEN;
          mot[d] = dsdc_pkg::MOT_IDLE;
          if (eflags[dsdc_pkg::EF_LOPEN + d]) begin
            eflags[dsdc_pkg::EF_LOPEN + d] = 1'b0;
            eflags[dsdc_pkg::EF_HELD]      = 1'b1;
            return 1'b0;
          end
          return 1'b1;
        end
      end else begin
        if (pos[d] > 0) pos[d] = pos[d] - 1'b1;
        if (pos[d] == 0) begin
          eflags[dsdc_pkg::EF_CLOSING] = 1'b0;
          mot[d]                       = dsdc_pkg::MOT_IDLE;
        end
      end
      return 1'b0;
    endfunction

    function void run_hold_timer(int d);
      int unsigned c;
      if (!hold_run[d]) return;
      c = hold_cnt[d] + 1;
      if (c < eff_ticks(period_r[dsdc_pkg::REG_HOLD])) begin
        hold_cnt[d] = c;
        return;
      end
      hold_cnt[d] = 0;
      hold_run[d] = 1'b0;
      mot[d]      = dsdc_pkg::MOT_CLOSE;
      step_cnt[d] = 0;
    endfunction

    function void note_tick(logic [2:0] lev);
      logic [2:0]  rise;
      bit          started [2];
      bit          held;
      int          n;
      lamp_frame_t f;
      rise     = lev & ~prev_lev;
      prev_lev = lev;
      for (int d = 0; d < 2; d++) begin
        if (rise[d] && eflags == 0) begin
          mot[d]      = dsdc_pkg::MOT_OPEN;
          step_cnt[d] = 0;
        end
      end
      if (rise[2]) begin
        held   = eflags[dsdc_pkg::EF_HELD];
        eflags = '0;
        if (held) begin
          eflags[dsdc_pkg::EF_CLOSING] = 1'b1;
          mot[0] = dsdc_pkg::MOT_CLOSE;
          mot[1] = dsdc_pkg::MOT_CLOSE;
        end else begin
          eflags[dsdc_pkg::EF_LOPEN] = 1'b1;
          eflags[dsdc_pkg::EF_ROPEN] = 1'b1;
          mot[0]   = dsdc_pkg::MOT_OPEN;
          mot[1]   = dsdc_pkg::MOT_OPEN;
          hold_run = '0;
        end
        step_cnt[0] = 0;
        step_cnt[1] = 0;
      end
      for (int d = 0; d < 2; d++) if (lev[d]) hold_cnt[d] = 0;
      for (int d = 0; d < 2; d++) started[d] = advance_door(d);
      for (int d = 0; d < 2; d++) if (!started[d]) run_hold_timer(d);
      for (int d = 0; d < 2; d++) begin
        if (started[d]) begin
          hold_cnt[d] = 0;
          hold_run[d] = 1'b1;
        end
      end
      n = (pos[0] > 4) ? 4 : pos[0];
      f.left_lamps = 4'(8'hF0 >> n);
      n = (pos[1] > 4) ? 4 : pos[1];
      f.right_lamps = 4'((1 << n) - 1);
      if (eflags[dsdc_pkg::EF_HELD])         f.mode = dsdc_pkg::MODE_HELD;
      else if (eflags[dsdc_pkg::EF_CLOSING]) f.mode = dsdc_pkg::MODE_CLOSING;
      else if (eflags[dsdc_pkg::EF_LOPEN] || eflags[dsdc_pkg::EF_ROPEN])
        f.mode = dsdc_pkg::MODE_OPENING;
      else                                   f.mode = dsdc_pkg::MODE_NORMAL;
      lamp_q.push_back(f);
    endfunction

    function int pending();
      return lamp_q.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_lamps(logic [15:0] data);
      lamp_frame_t f;
      rx_count++;
      if (lamp_q.size() == 0) begin
        report($sformatf("result %0d (%h) with nothing pending", rx_count, data));
        return;
      end
      f = lamp_q.pop_front();
      if (data[3:0] !== f.left_lamps)
        report($sformatf("result %0d left_lamps %h, want %h", rx_count, data[3:0],
                         f.left_lamps));
      if (data[7:4] !== f.right_lamps)
        report($sformatf("result %0d right_lamps %h, want %h", rx_count, data[7:4],
                         f.right_lamps));
      if (data[9:8] !== f.mode)
        report($sformatf("result %0d mode %0d, want %0d", rx_count, data[9:8], f.mode));
    endtask

    task report_leftover();
      if (lamp_q.size() != 0)
        report($sformatf("%0d results never arrived", lamp_q.size()));
    endtask
  endclass

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [7:0]                     s_axis_tdata  = '0;  // left, right, emergency, pad
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [15:0]                    m_axis_tdata;        // left_lamps, right_lamps, mode, pad
  logic                           cfg_valid_i   = 1'b0;
  logic                           cfg_ready_o;
  logic [dsdc_pkg::CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [dsdc_pkg::CFG_W-1:0]     cfg_data_i    = '0;

  door_scoreboard sb;
  bit             no_idle = 1'b0;
  int             stall_cycles = 0;

  always #4 clk_i = ~clk_i;

  dual_sliding_door_controller DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_dual_sliding_door_controller NOT OK");
      $finish;
    end
  end

  // entered and left at a falling edge
  task send_tick(input logic [2:0] lev);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, lev};
    @(posedge clk_i);
    while (!(s_axis_tvalid && s_axis_tready)) @(posedge clk_i);
    sb.note_tick(lev);
    @(negedge clk_i);
  endtask

  task drain_outputs();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task write_reg(input logic [dsdc_pkg::CFG_IDX_W-1:0] idx,
                 input logic [dsdc_pkg::CFG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!(cfg_valid_i && cfg_ready_o)) @(posedge clk_i);
    sb.set_period(idx, val);
    @(negedge clk_i);
  endtask

  task load_periods(input logic [dsdc_pkg::CFG_W-1:0] open_t,
                    input logic [dsdc_pkg::CFG_W-1:0] close_t,
                    input logic [dsdc_pkg::CFG_W-1:0] hold_t);
    drain_outputs();
    write_reg(dsdc_pkg::REG_OPEN_STEP, open_t);
    write_reg(dsdc_pkg::REG_CLOSE_STEP, close_t);
    write_reg(dsdc_pkg::REG_HOLD, hold_t);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int gap;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!(m_axis_tvalid && m_axis_tready)) @(posedge clk_i);
      sb.check_lamps(m_axis_tdata);
      @(negedge clk_i);
    end
  end

  // {emergency, right, left}; open and close periods of zero, hold of three
  localparam logic [2:0] DIRECTED [DIRECTED_LEN] = '{
    3'b001, 3'b000, 3'b000, 3'b000, 3'b001, 3'b001, 3'b000, 3'b000, 3'b000,
    3'b000, 3'b010, 3'b001, 3'b111, 3'b000, 3'b011, 3'b000, 3'b000, 3'b100,
    3'b000, 3'b110, 3'b000, 3'b000, 3'b100, 3'b000, 3'b000, 3'b000, 3'b000
  };

  initial begin
    logic [2:0]                 lev;
    int                         ticks;
    int                         psen;
    int                         pemg;
    int                         quiet;
    logic [dsdc_pkg::CFG_W-1:0] hold_t;
    sb = new();
    lev   = '0;
    quiet = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset periods: only counting, no door reaches open this soon
    for (int i = 0; i < 10; i++) send_tick(3'($urandom_range(0, 3)));
    send_tick(3'b000);

    load_periods(17'd0, 17'd0, 17'd3);
    for (int i = 0; i < DIRECTED_LEN; i++) send_tick(DIRECTED[i]);
    lev = DIRECTED[DIRECTED_LEN-1];

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      unique case (ph)
        0: load_periods(17'h1FFFF, 17'h10000, 17'h10000);
        1: load_periods(17'd1, 17'd1, 17'd1);
        default: begin
          hold_t = ($urandom_range(0, 3) == 0) ? dsdc_pkg::CFG_W'($urandom_range(13, 40))
                                               : dsdc_pkg::CFG_W'($urandom_range(1, 12));
          load_periods(dsdc_pkg::CFG_W'($urandom_range(1, 4)),
                       dsdc_pkg::CFG_W'($urandom_range(1, 4)), hold_t);
        end
      endcase
      no_idle = (ph % 3 == 2);
      psen    = $urandom_range(2, 12);
      pemg    = $urandom_range(8, 40);
      ticks   = (ph == 0) ? 60 : PHASE_TICKS;
      for (int i = 0; i < ticks; i++) begin
        if (i == ticks / 2 && (ph == 2 || $urandom_range(0, 2) == 0)) drain_outputs();
        if (quiet > 0) quiet--;
        else if ($urandom_range(0, 29) == 0) quiet = $urandom_range(10, 40);
        for (int b = 0; b < 3; b++) begin
          if ($urandom_range(0, ((b == 2) ? pemg : psen) - 1) == 0) lev[b] = ~lev[b];
        end
        if (quiet > 0) lev[1:0] = 2'b00;
        send_tick(lev);
      end
    end

    no_idle = 1'b0;
    drain_outputs();
    repeat (8) @(negedge clk_i);
    sb.report_leftover();
    if (sb.errors == 0) begin
      $display("tb_dual_sliding_door_controller OK");
    end else begin
      $display("tb_dual_sliding_door_controller NOT OK");
    end
    $finish;
  end

endmodule

// ----- dual_sliding_door_controller.f -----
sv/dsdc_pkg.sv
sv/dsdc_door.sv
sv/dual_sliding_door_controller.sv
tb/tb_dual_sliding_door_controller.sv
